// ===== design/nfha_pkg.sv =====
`timescale 1ns / 1ps

package nfha_pkg;

    localparam int POOL_UNITS_DEF   = 1024;
    localparam int HEADER_UNITS_DEF = 1;

    localparam logic [6:0] MIN_REM_RESET = 7'd2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [9:0] request_units;
        logic [9:0] release_addr;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  block_addr;
        logic [10:0] free_units;
        logic [10:0] live_blocks;
    } out_t;

endpackage

// ===== design/nfha_ram.sv =====
`timescale 1ns / 1ps

module nfha_ram #(
    parameter int DW    = 23,
    parameter int AW    = 10,
    parameter int DEPTH = 1024
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/next_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// an allocate reads the rover header, then visits block headers next-fit until one fits; a split
// writes the remainder header and mends the following block's back link; a release checks the
// header, merges free neighbours and writes the merged header; a release turned away goes to the result
// one command at a time, set by the single port of the block table: busy stays high until
// the result word, and the next start is taken at the earliest with the edge that ends it
// after reset the table is swept one entry a cycle, all POOL_UNITS entries, busy high
// the result is shown for one cycle on done; the receiver cannot stall
module next_fit_heap_allocator #(
    parameter int POOL_UNITS   = nfha_pkg::POOL_UNITS_DEF,
    parameter int HEADER_UNITS = nfha_pkg::HEADER_UNITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  nfha_pkg::in_t  cmd,
    input  logic           cfg_we,
    input  logic [6:0]     cfg_data,
    output logic           done,
    output nfha_pkg::out_t result
);

    localparam int AW    = $clog2(POOL_UNITS);
    localparam int EXT_W = AW + 1;
    localparam int CW    = (EXT_W > 11) ? EXT_W : 11;
    localparam int WW    = 2 + EXT_W + AW;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ROV   = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_ASPL  = 4'd4;
    localparam logic [3:0] S_FXRD  = 4'd5;
    localparam logic [3:0] S_FXWR  = 4'd6;
    localparam logic [3:0] S_RCHK  = 4'd7;
    localparam logic [3:0] S_RPRV  = 4'd8;
    localparam logic [3:0] S_RNXI  = 4'd9;
    localparam logic [3:0] S_RNXD  = 4'd10;
    localparam logic [3:0] S_RWCUR = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    localparam logic [EXT_W-1:0] POOL_E = EXT_W'(POOL_UNITS);
    localparam logic [CW-1:0]    HDR_C  = CW'(HEADER_UNITS);

    logic [3:0]       state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             op_reg, op_next;
    logic [CW-1:0]    need_reg, need_next;
    logic [AW-1:0]    first_reg, first_next;
    logic [AW-1:0]    b_reg, b_next;
    logic [AW:0]      steps_reg, steps_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [EXT_W-1:0] cur_ext_reg, cur_ext_next;
    logic [AW-1:0]    cur_prev_reg, cur_prev_next;
    logic [AW-1:0]    s_reg, s_next;
    logic [EXT_W-1:0] nx_reg, nx_next;
    logic [AW-1:0]    fix_addr_reg, fix_addr_next;
    logic [AW-1:0]    fix_val_reg, fix_val_next;
    logic [AW-1:0]    rover_reg, rover_next;
    logic [EXT_W-1:0] free_reg, free_next;
    logic [EXT_W-1:0] live_reg, live_next;
    logic [6:0]       minr_reg;
    logic [1:0]       status_reg, status_next;
    logic [9:0]       baddr_reg, baddr_next;
    logic             done_reg, done_next;
    nfha_pkg::out_t   out_reg, out_next;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [WW-1:0]    mem_wdata;
    logic [WW-1:0]    rd;

    logic             rd_start, rd_free;
    logic [EXT_W-1:0] rd_ext;
    logic [AW-1:0]    rd_prev;
    logic [CW-1:0]    rel_s;
    logic [EXT_W-1:0] left;
    logic [6:0]       minr_eff;
    logic             split;
    logic [EXT_W-1:0] step_sz;
    logic [EXT_W-1:0] walk_nb;
    logic [EXT_W-1:0] after;

    nfha_ram #(
        .DW    (WW),
        .AW    (AW),
        .DEPTH (POOL_UNITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rd)
    );

    assign rd_start = rd[WW-1];
    assign rd_free  = rd[WW-2];
    assign rd_ext   = rd[AW+EXT_W-1:AW];
    assign rd_prev  = rd[AW-1:0];

    assign minr_eff = (minr_reg == 7'd0) ? 7'd1 : minr_reg;
    assign left     = rd_ext - EXT_W'(need_reg);
    assign split    = CW'(left) >= CW'(minr_eff);
    assign step_sz  = (rd_ext == '0) ? EXT_W'(1) : rd_ext;
    assign walk_nb  = EXT_W'(b_reg) + step_sz;
    assign after    = nx_reg + rd_ext;
    assign rel_s    = CW'(cmd.release_addr) - HDR_C;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        op_next       = op_reg;
        need_next     = need_reg;
        first_next    = first_reg;
        b_next        = b_reg;
        steps_next    = steps_reg;
        cur_next      = cur_reg;
        cur_ext_next  = cur_ext_reg;
        cur_prev_next = cur_prev_reg;
        s_next        = s_reg;
        nx_next       = nx_reg;
        fix_addr_next = fix_addr_reg;
        fix_val_next  = fix_val_reg;
        rover_next    = rover_reg;
        free_next     = free_reg;
        live_next     = live_reg;
        status_next   = status_reg;
        baddr_next    = baddr_reg;
        done_next     = 1'b0;
        out_next      = out_reg;
        mem_we        = 1'b0;
        mem_addr      = b_reg;
        mem_wdata     = '0;

        unique case (state_reg)
            S_CLR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                if (clr_reg == '0)
                begin
                    mem_wdata  = {1'b1, 1'b1, POOL_E, AW'(0)};
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg - AW'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = cmd.opcode;
                    status_next = nfha_pkg::ST_OK;
                    baddr_next  = '0;
                    if (cmd.opcode == nfha_pkg::OP_ALLOC)
                    begin
                        need_next  = ((cmd.request_units == '0) ? CW'(1)
                                     : CW'(cmd.request_units)) + HDR_C;
                        mem_addr   = rover_reg;
                        state_next = S_ROV;
                    end
                    else if (CW'(cmd.release_addr) < HDR_C
                             || rel_s >= CW'(POOL_UNITS))
                    begin
                        status_next = nfha_pkg::ST_BAD;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        s_next     = rel_s[AW-1:0];
                        mem_addr   = rel_s[AW-1:0];
                        state_next = S_RCHK;
                    end
                end
            end
            S_ROV:
            begin
                first_next = rd_start ? rover_reg : '0;
                b_next     = rd_start ? rover_reg : '0;
                mem_addr   = rd_start ? rover_reg : '0;
                steps_next = '0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (rd_free && CW'(rd_ext) >= need_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = {1'b1, 1'b0, split ? EXT_W'(need_reg) : rd_ext, rd_prev};
                    free_next  = free_reg - (split ? EXT_W'(need_reg) : rd_ext);
                    live_next  = live_reg + EXT_W'(1);
                    baddr_next = 10'(CW'(b_reg) + HDR_C);
                    if (split)
                    begin
                        cur_next     = AW'(CW'(b_reg) + need_reg);
                        cur_ext_next = left;
                        nx_next      = EXT_W'(b_reg) + rd_ext;
                        state_next   = S_ASPL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    b_next     = (walk_nb >= POOL_E) ? '0 : walk_nb[AW-1:0];
                    steps_next = steps_reg + (AW+1)'(1);
                    mem_addr   = b_next;
                    if (b_next == first_reg || steps_next == (AW+1)'(POOL_UNITS))
                    begin
                        status_next = nfha_pkg::ST_OOM;
                        state_next  = S_DONE;
                    end
                end
            end
            S_ASPL:
            begin
                mem_we    = 1'b1;
                mem_addr  = cur_reg;
                mem_wdata = {1'b1, 1'b1, cur_ext_reg, b_reg};
                if (nx_reg < POOL_E)
                begin
                    fix_addr_next = nx_reg[AW-1:0];
                    fix_val_next  = cur_reg;
                    state_next    = S_FXRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FXRD:
            begin
                mem_addr   = fix_addr_reg;
                state_next = S_FXWR;
            end
            S_FXWR:
            begin
                mem_we     = 1'b1;
                mem_addr   = fix_addr_reg;
                mem_wdata  = {rd[WW-1:AW], fix_val_reg};
                state_next = (op_reg == nfha_pkg::OP_RELEASE) ? S_RWCUR : S_DONE;
            end
            S_RCHK:
            begin
                if (!rd_start || rd_free)
                begin
                    status_next = nfha_pkg::ST_BAD;
                    state_next  = S_DONE;
                end
                else
                begin
                    free_next     = free_reg + rd_ext;
                    live_next     = live_reg - EXT_W'(1);
                    cur_next      = s_reg;
                    cur_ext_next  = rd_ext;
                    cur_prev_next = rd_prev;
                    nx_next       = EXT_W'(s_reg) + rd_ext;
                    if (s_reg != '0)
                    begin
                        rover_next = rd_prev;
                        mem_addr   = rd_prev;
                        state_next = S_RPRV;
                    end
                    else
                    begin
                        rover_next = '0;
                        state_next = S_RNXI;
                    end
                end
            end
            S_RPRV:
            begin
                if (rd_start && rd_free)
                begin
                    mem_we        = 1'b1;
                    mem_addr      = s_reg;
                    mem_wdata     = '0;
                    cur_next      = rover_reg;
                    cur_ext_next  = cur_ext_reg + rd_ext;
                    cur_prev_next = rd_prev;
                end
                state_next = S_RNXI;
            end
            S_RNXI:
            begin
                if (nx_reg < POOL_E)
                begin
                    mem_addr   = nx_reg[AW-1:0];
                    state_next = S_RNXD;
                end
                else
                begin
                    state_next = S_RWCUR;
                end
            end
            S_RNXD:
            begin
                mem_we   = 1'b1;
                mem_addr = nx_reg[AW-1:0];
                if (rd_start && rd_free)
                begin
                    mem_wdata    = '0;
                    cur_ext_next = cur_ext_reg + rd_ext;
                    if (after < POOL_E)
                    begin
                        fix_addr_next = after[AW-1:0];
                        fix_val_next  = cur_reg;
                        state_next    = S_FXRD;
                    end
                    else
                    begin
                        state_next = S_RWCUR;
                    end
                end
                else
                begin
                    mem_wdata  = {rd[WW-1:AW], cur_reg};
                    state_next = S_RWCUR;
                end
            end
            S_RWCUR:
            begin
                mem_we     = 1'b1;
                mem_addr   = cur_reg;
                mem_wdata  = {1'b1, 1'b1, cur_ext_reg, cur_prev_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next            = 1'b1;
                out_next.status      = status_reg;
                out_next.block_addr  = baddr_reg;
                out_next.free_units  = 11'(free_reg);
                out_next.live_blocks = 11'(live_reg);
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= AW'(POOL_UNITS - 1);
            rover_reg <= '0;
            free_reg  <= POOL_E;
            live_reg  <= '0;
            minr_reg  <= nfha_pkg::MIN_REM_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rover_reg <= rover_next;
            free_reg  <= free_next;
            live_reg  <= live_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                minr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        need_reg     <= need_next;
        first_reg    <= first_next;
        b_reg        <= b_next;
        steps_reg    <= steps_next;
        cur_reg      <= cur_next;
        cur_ext_reg  <= cur_ext_next;
        cur_prev_reg <= cur_prev_next;
        s_reg        <= s_next;
        nx_reg       <= nx_next;
        fix_addr_reg <= fix_addr_next;
        fix_val_reg  <= fix_val_next;
        status_reg   <= status_next;
        baddr_reg    <= baddr_next;
        out_reg      <= out_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = out_reg;

endmodule

// ===== design/nfha_checker.sv =====
`timescale 1ns / 1ps

module nfha_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input nfha_pkg::out_t result
);

    // a word is only ever shown after the block has been working
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without preceding work");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == nfha_pkg::ST_OK || result.status == nfha_pkg::ST_OOM
                  || result.status == nfha_pkg::ST_BAD))
        else $error("status code out of range");

    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != nfha_pkg::ST_OK) |-> (result.block_addr == '0))
        else $error("failed word carries an address");

endmodule

bind next_fit_heap_allocator nfha_checker u_nfha_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int POOL   = 1024;
    localparam int HDR    = 1;
    localparam int LIMIT  = 3000000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    nfha_pkg::in_t  cmd;
    logic           cfg_we;
    logic [6:0]     cfg_data;
    logic           done;
    nfha_pkg::out_t result;

    next_fit_heap_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    // pool shadow
    bit          is_start [POOL];
    bit          is_free  [POOL];
    int unsigned extent   [POOL];
    int unsigned prev_blk [POOL];
    int unsigned rover_q;
    int unsigned free_sum;
    int unsigned live_sum;
    logic [6:0]  min_rem;

    nfha_pkg::out_t pending_words [$];
    int unsigned    granted [$];
    int             errors;
    longint         cycles;

    typedef struct {
        logic       op;
        logic [9:0] req;
        logic [9:0] addr;
        bit         fixed;
        logic [1:0] st;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic void pool_reset();
        for (int i = 0; i < POOL; i++)
        begin
            is_start[i] = 0;
            is_free[i]  = 0;
            extent[i]   = 0;
            prev_blk[i] = 0;
        end
        is_start[0] = 1;
        is_free[0]  = 1;
        extent[0]   = POOL;
        rover_q  = 0;
        free_sum = POOL;
        live_sum = 0;
    endfunction

    function automatic void merge_into(int unsigned a, int unsigned b);
        int unsigned nxt;
        nxt = b + extent[b];
        extent[a] += extent[b];
        is_start[b] = 0;
        is_free[b]  = 0;
        extent[b]   = 0;
        if (nxt < POOL)
            prev_blk[nxt] = a;
    endfunction

    function automatic nfha_pkg::out_t predict_word(nfha_pkg::in_t c);
        nfha_pkg::out_t w;
        int unsigned    need, first, b, steps, left, mr, nb, s, nx, cur, p;
        bit             hit;
        w = '0;
        hit = 0;
        if (c.opcode == nfha_pkg::OP_ALLOC)
        begin
            need  = ((c.request_units == 0) ? 1 : c.request_units) + HDR;
            first = (rover_q < POOL && is_start[rover_q]) ? rover_q : 0;
            b = first;
            steps = 0;
            do
            begin
                if (is_free[b] && extent[b] >= need)
                begin
                    hit = 1;
                    break;
                end
                b += (extent[b] == 0) ? 1 : extent[b];
                if (b >= POOL)
                    b = 0;
                steps++;
            end
            while (b != first && steps < POOL);
            if (!hit)
                w.status = nfha_pkg::ST_OOM;
            else
            begin
                left = extent[b] - need;
                mr = (min_rem == 0) ? 1 : min_rem;
                if (left >= mr)
                begin
                    nb = b + need;
                    is_start[nb] = 1;
                    is_free[nb]  = 1;
                    extent[nb]   = left;
                    prev_blk[nb] = b;
                    if (nb + left < POOL)
                        prev_blk[nb + left] = nb;
                    extent[b] = need;
                end
                is_free[b] = 0;
                free_sum -= extent[b];
                live_sum++;
                w.status = nfha_pkg::ST_OK;
                w.block_addr = 10'(b + HDR);
            end
        end
        else if (c.release_addr < HDR || !is_start[c.release_addr - HDR]
                 || is_free[c.release_addr - HDR])
            w.status = nfha_pkg::ST_BAD;
        else
        begin
            s = c.release_addr - HDR;
            is_free[s] = 1;
            free_sum += extent[s];
            live_sum--;
            nx = s + extent[s];
            cur = s;
            if (s != 0)
            begin
                p = prev_blk[s];
                if (p < POOL && is_start[p] && is_free[p])
                begin
                    merge_into(p, s);
                    cur = p;
                end
                rover_q = (p < POOL) ? p : 0;
            end
            else
                rover_q = s;
            if (nx < POOL && is_start[nx] && is_free[nx])
                merge_into(cur, nx);
            w.status = nfha_pkg::ST_OK;
        end
        w.free_units  = 11'(free_sum);
        w.live_blocks = 11'(live_sum);
        return w;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        nfha_pkg::out_t exp_w;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, result);
                errors++;
            end
            else
            begin
                exp_w = pending_words.pop_front();
                if (result.status !== exp_w.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, exp_w.status,
                             result.status);
                    errors++;
                end
                if (result.block_addr !== exp_w.block_addr)
                begin
                    $display("%0t: block_addr exp %0d got %0d", $time,
                             exp_w.block_addr, result.block_addr);
                    errors++;
                end
                if (result.free_units !== exp_w.free_units)
                begin
                    $display("%0t: free_units exp %0d got %0d", $time,
                             exp_w.free_units, result.free_units);
                    errors++;
                end
                if (result.live_blocks !== exp_w.live_blocks)
                begin
                    $display("%0t: live_blocks exp %0d got %0d", $time,
                             exp_w.live_blocks, result.live_blocks);
                    errors++;
                end
            end
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        repeat (n) @(posedge clk);
    endtask

    task automatic issue(nfha_pkg::in_t c, bit fixed, logic [1:0] st, bit gaps);
        nfha_pkg::out_t w;
        while (busy)
            @(posedge clk);
        w = predict_word(c);
        if (fixed && w.status !== st)
        begin
            $display("%0t: table status exp %0d model %0d", $time, st, w.status);
            errors++;
        end
        pending_words = {pending_words, w};
        if (c.opcode == nfha_pkg::OP_ALLOC && w.status == nfha_pkg::ST_OK)
            granted = {granted, int'(w.block_addr)};
        if (c.opcode == nfha_pkg::OP_RELEASE && w.status == nfha_pkg::ST_OK)
        begin
            foreach (granted[i])
            begin
                if (granted[i] == c.release_addr)
                begin
                    granted.delete(i);
                    break;
                end
            end
        end
        cmd   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b1 && done !== 1'b1 && pending_words.size() != 0)
            @(posedge clk);
        if (gaps && $urandom_range(0, 3) != 0)
        begin
            start <= 1'b0;
            idle_gap();
        end
        else
            start <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while ((pending_words.size() != 0 || busy) && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic set_min_rem(logic [6:0] v);
        drain();
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        min_rem = v;
    endtask

    task automatic random_phase(int n);
        nfha_pkg::in_t c;
        int            k;
        for (int i = 0; i < n; i++)
        begin
            c = '0;
            k = $urandom_range(0, 99);
            if (k < 45)
            begin
                c.opcode = nfha_pkg::OP_ALLOC;
                c.request_units = ($urandom_range(0, 19) == 0) ? 10'($urandom)
                                  : 10'($urandom_range(0, 40));
                c.release_addr = 10'($urandom);
            end
            else if (k < 88 && granted.size() != 0)
            begin
                c.opcode = nfha_pkg::OP_RELEASE;
                c.release_addr = 10'(granted[$urandom_range(0, granted.size() - 1)]);
                c.request_units = 10'($urandom);
            end
            else
            begin
                c.opcode = nfha_pkg::OP_RELEASE;
                c.release_addr = 10'($urandom);
                c.request_units = 10'($urandom);
            end
            issue(c, 0, nfha_pkg::ST_OK, 1);
        end
    endtask

    initial
    begin
        row_t          dir [$];
        nfha_pkg::in_t c;
        errors = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_data = nfha_pkg::MIN_REM_RESET;
        min_rem = nfha_pkg::MIN_REM_RESET;
        pool_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir = '{
            '{nfha_pkg::OP_RELEASE, 10'd0,    10'd1,    1, nfha_pkg::ST_BAD},
            '{nfha_pkg::OP_RELEASE, 10'd0,    10'd0,    1, nfha_pkg::ST_BAD},
            '{nfha_pkg::OP_ALLOC,   10'd1023, 10'd0,    1, nfha_pkg::ST_OK},
            '{nfha_pkg::OP_RELEASE, 10'd0,    10'd1,    1, nfha_pkg::ST_OK},
            '{nfha_pkg::OP_ALLOC,   10'd0,    10'd1023, 0, nfha_pkg::ST_OK},
            '{nfha_pkg::OP_ALLOC,   10'd5,    10'd0,    0, nfha_pkg::ST_OK},
            '{nfha_pkg::OP_ALLOC,   10'd10,   10'd0,    0, nfha_pkg::ST_OK},
            '{nfha_pkg::OP_RELEASE, 10'd0,    10'd3,    0, nfha_pkg::ST_OK},
            '{nfha_pkg::OP_RELEASE, 10'd0,    10'd3,    1, nfha_pkg::ST_BAD},
            '{nfha_pkg::OP_RELEASE, 10'd0,    10'd1023, 1, nfha_pkg::ST_BAD},
            '{nfha_pkg::OP_RELEASE, 10'd1023, 10'd5,    1, nfha_pkg::ST_BAD},
            '{nfha_pkg::OP_ALLOC,   10'd3,    10'd0,    0, nfha_pkg::ST_OK},
            '{nfha_pkg::OP_RELEASE, 10'd0,    10'd1,    0, nfha_pkg::ST_OK},
            '{nfha_pkg::OP_ALLOC,   10'd1000, 10'd0,    0, nfha_pkg::ST_OK},
            '{nfha_pkg::OP_ALLOC,   10'd512,  10'd0,    1, nfha_pkg::ST_OOM},
            '{nfha_pkg::OP_ALLOC,   10'd2,    10'd0,    0, nfha_pkg::ST_OK}
        };
        foreach (dir[i])
        begin
            c.opcode = dir[i].op;
            c.request_units = dir[i].req;
            c.release_addr = dir[i].addr;
            issue(c, dir[i].fixed, dir[i].st, 0);
        end
        while (granted.size() != 0)
        begin
            c = '0;
            c.opcode = nfha_pkg::OP_RELEASE;
            c.release_addr = 10'(granted[0]);
            issue(c, 0, nfha_pkg::ST_OK, 0);
        end

        set_min_rem(7'd0);
        random_phase(140);
        set_min_rem(7'd127);
        random_phase(140);
        set_min_rem(7'd1);
        random_phase(140);
        drain();
        set_min_rem(7'd64);
        random_phase(140);
        set_min_rem(7'($urandom_range(1, 64)));
        random_phase(140);

        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
